[design/rwcp_pkg.sv]
// Package for the RIFF/WAVE chunk parser: word types, chunk tags, result kinds.
// No dependencies; imported by riff_wave_chunk_parser_top.
package rwcp_pkg;

    // Four-character codes, first character in the low byte
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [9:0] MS_PER_S = 10'd1000;

    // Result kinds
    localparam logic [2:0] KIND_PCM       = 3'd0;
    localparam logic [2:0] KIND_COMPRESS  = 3'd1;
    localparam logic [2:0] KIND_BAD_RIFF  = 3'd2;
    localparam logic [2:0] KIND_BAD_WAVE  = 3'd3;
    localparam logic [2:0] KIND_NO_DATA   = 3'd4;
    localparam logic [2:0] KIND_ZERO_RATE = 3'd5;

    // Duration divider: quotient width, one bit per step
    localparam int LEN_MS_W  = 42;
    localparam int DIV_STEPS = LEN_MS_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Input word
    typedef struct packed {
        logic [7:0] byte_in;
        logic       first;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [2:0]          kind;
        logic [7:0]          pcm_byte;
        logic                last;
        logic [15:0]         format_tag;
        logic [15:0]         channels;
        logic [31:0]         sample_rate;
        logic [31:0]         byte_rate;
        logic [15:0]         block_align;
        logic [15:0]         bits_per_sample;
        logic [31:0]         data_length;
        logic [LEN_MS_W-1:0] length_ms;
    } t_out_word;

    // Parser phase, one-hot
    typedef enum logic [9:0] {
        PH_RIFF = 10'b00_0000_0001,
        PH_RLEN = 10'b00_0000_0010,
        PH_WAVE = 10'b00_0000_0100,
        PH_CTAG = 10'b00_0000_1000,
        PH_CLEN = 10'b00_0001_0000,
        PH_FMT  = 10'b00_0010_0000,
        PH_DATA = 10'b00_0100_0000,
        PH_SKIP = 10'b00_1000_0000,
        PH_PAD  = 10'b01_0000_0000,
        PH_DONE = 10'b10_0000_0000
    } t_phase;

    // Duration sequencer, one-hot
    typedef enum logic [2:0] {
        SQ_IDLE = 3'b001,
        SQ_MUL  = 3'b010,
        SQ_DIV  = 3'b100
    } t_seq;

endpackage

[design/riff_wave_chunk_parser_top.sv]
// RIFF/WAVE chunk parser top level: byte parser, result register, duration divider.
// Depends on rwcp_pkg for word types, tags, kinds and phase codes.
//
// Takes a WAV file one byte per word and returns at most one result word per byte:
// PCM data bytes, a compressed warning on a fact chunk, a tag or missing-data
// error, or a zero-rate kind on a last byte with byte rate 0. The parser takes
// one byte per cycle unless stalled. The final data byte carries the fmt summary
// and the duration in ms (data_length*1000/byte_rate); at a nonzero byte rate it
// passes a multiply state and a 42-bit restoring divider (one quotient bit per
// cycle), stalling the input meanwhile. Raise first on the first byte of each file.
module riff_wave_chunk_parser_top
    import rwcp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    // Parser state
    t_phase       r_phase, n_phase;
    logic [31:0]  r_fc, n_fc;
    logic [31:0]  r_tag, n_tag;
    logic [31:0]  r_len, n_len;
    logic [31:0]  r_wend, n_wend;
    logic [31:0]  r_walked, n_walked;
    logic [127:0] r_fmt, n_fmt;

    // Result register and duration sequencer
    logic                r_out_valid;
    t_out_word           r_out;
    t_seq                r_seq;
    logic [LEN_MS_W-1:0] r_quo;
    logic [31:0]         r_rem;
    logic [CNT_W-1:0]    r_cnt;

    logic        accept;
    logic        res_valid;
    logic [2:0]  res_kind;
    logic [7:0]  res_byte;
    logic        res_last;
    logic        do_next;
    logic        do_end;
    logic        warn;
    logic        no_data;
    logic [31:0] fc_inc;
    logic [31:0] fc_dec;
    logic [31:0] fmt_idx;
    t_out_word   res_word;

    // Divider step
    logic [32:0] div_trial;
    logic        div_ge;
    logic [31:0] div_rem;

    assign o_stall = (r_seq != SQ_IDLE) || (r_out_valid && i_stall);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Byte parser: next state and result for one byte
    always_comb begin
        n_phase   = r_phase;
        n_fc      = r_fc;
        n_tag     = r_tag;
        n_len     = r_len;
        n_wend    = r_wend;
        n_walked  = r_walked;
        n_fmt     = r_fmt;
        res_valid = 1'b0;
        res_kind  = KIND_PCM;
        res_byte  = 8'd0;
        res_last  = 1'b0;
        do_next   = 1'b0;
        do_end    = 1'b0;
        warn      = 1'b0;
        no_data   = 1'b0;
        fmt_idx   = 32'd0;

        if (i_data.first) begin
            n_phase  = PH_RIFF;
            n_fc     = 32'd0;
            n_tag    = 32'd0;
            n_len    = 32'd0;
            n_wend   = 32'd0;
            n_walked = 32'd0;
            n_fmt    = 128'd0;
        end

        // walk counter runs over chunk bytes, saturating
        if ((n_phase == PH_CTAG || n_phase == PH_CLEN || n_phase == PH_FMT ||
             n_phase == PH_DATA || n_phase == PH_SKIP || n_phase == PH_PAD) &&
            n_walked != 32'hFFFF_FFFF) begin
            n_walked = n_walked + 32'd1;
        end

        fc_inc = n_fc + 32'd1;
        fc_dec = n_fc - 32'd1;

        unique case (n_phase)
            PH_RIFF, PH_WAVE: begin
                n_tag = {i_data.byte_in, n_tag[31:8]};
                if (fc_inc < 32'd4) begin
                    n_fc = fc_inc;
                end else begin
                    n_fc = 32'd0;
                    if (n_phase == PH_RIFF) begin
                        if (n_tag != TAG_RIFF) begin
                            n_phase   = PH_DONE;
                            res_valid = 1'b1;
                            res_kind  = KIND_BAD_RIFF;
                        end else begin
                            n_len   = 32'd0;
                            n_phase = PH_RLEN;
                        end
                    end else if (n_tag != TAG_WAVE) begin
                        n_phase   = PH_DONE;
                        res_valid = 1'b1;
                        res_kind  = KIND_BAD_WAVE;
                    end else begin
                        n_fmt    = 128'd0;
                        n_walked = 32'd0;
                        do_next  = 1'b1;
                    end
                end
            end
            PH_RLEN: begin
                n_len = {i_data.byte_in, n_len[31:8]};
                if (fc_inc < 32'd4) begin
                    n_fc = fc_inc;
                end else begin
                    n_fc    = 32'd0;
                    n_wend  = (n_len >= 32'd4) ? n_len - 32'd4 : 32'd0;
                    n_tag   = 32'd0;
                    n_phase = PH_WAVE;
                end
            end
            PH_CTAG: begin
                n_tag = {i_data.byte_in, n_tag[31:8]};
                if (fc_inc < 32'd4) begin
                    n_fc = fc_inc;
                end else begin
                    n_fc    = 32'd0;
                    n_len   = 32'd0;
                    n_phase = PH_CLEN;
                end
            end
            PH_CLEN: begin
                n_len = {i_data.byte_in, n_len[31:8]};
                if (fc_inc < 32'd4) begin
                    n_fc = fc_inc;
                end else begin
                    n_fc = n_len;
                    warn = (n_tag == TAG_FACT);
                    if (n_len != 32'd0) begin
                        if (n_tag == TAG_FMT) begin
                            n_phase = PH_FMT;
                        end else if (n_tag == TAG_DATA) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        do_end = 1'b1;
                    end
                end
            end
            PH_FMT: begin
                // first sixteen body bytes land in the format field image
                fmt_idx = n_len - n_fc;
                if (fmt_idx < 32'd16) begin
                    n_fmt[{fmt_idx[3:0], 3'b000} +: 8] = i_data.byte_in;
                end
                n_fc = fc_dec;
                if (fc_dec == 32'd0) begin
                    do_end = 1'b1;
                end
            end
            PH_SKIP: begin
                n_fc = fc_dec;
                if (fc_dec == 32'd0) begin
                    do_end = 1'b1;
                end
            end
            PH_PAD: begin
                do_next = 1'b1;
            end
            PH_DATA: begin
                n_fc      = fc_dec;
                res_valid = 1'b1;
                res_byte  = i_data.byte_in;
                if (fc_dec == 32'd0) begin
                    n_phase  = PH_DONE;
                    res_last = 1'b1;
                    res_kind = (n_fmt[95:64] != 32'd0) ? KIND_PCM : KIND_ZERO_RATE;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        // end of body: pad byte after odd length, else next chunk
        if (do_end) begin
            if (n_len[0]) begin
                n_phase = PH_PAD;
            end else begin
                do_next = 1'b1;
            end
        end

        // next chunk header, or give up once the walk is spent
        if (do_next) begin
            if (n_walked >= n_wend) begin
                n_phase   = PH_DONE;
                no_data   = 1'b1;
                res_valid = 1'b1;
                res_kind  = KIND_NO_DATA;
            end else begin
                n_phase = PH_CTAG;
                n_fc    = 32'd0;
                n_tag   = 32'd0;
            end
        end

        if (warn && !no_data) begin
            res_valid = 1'b1;
            res_kind  = KIND_COMPRESS;
        end
    end

    // Result word; summary fields only on the last data byte
    always_comb begin
        res_word           = '0;
        res_word.kind      = res_kind;
        res_word.pcm_byte  = res_byte;
        res_word.last      = res_last;
        if (res_last) begin
            res_word.format_tag      = n_fmt[15:0];
            res_word.channels        = n_fmt[31:16];
            res_word.sample_rate     = n_fmt[63:32];
            res_word.byte_rate       = n_fmt[95:64];
            res_word.block_align     = n_fmt[111:96];
            res_word.bits_per_sample = n_fmt[127:112];
            res_word.data_length     = n_len;
        end
    end

    // Restoring divider step: one quotient bit
    assign div_trial = {r_rem, r_quo[LEN_MS_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_out.byte_rate};
    assign div_rem   = div_ge ? 32'(div_trial - {1'b0, r_out.byte_rate}) : div_trial[31:0];

    // Parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_RIFF;
            r_fc     <= 32'd0;
            r_tag    <= 32'd0;
            r_len    <= 32'd0;
            r_wend   <= 32'd0;
            r_walked <= 32'd0;
            r_fmt    <= 128'd0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_fc     <= n_fc;
            r_tag    <= n_tag;
            r_len    <= n_len;
            r_wend   <= n_wend;
            r_walked <= n_walked;
            r_fmt    <= n_fmt;
        end
    end

    // Result register and duration sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_seq       <= SQ_IDLE;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_seq)
                SQ_IDLE: begin
                    if (accept && res_valid) begin
                        if (res_last && res_word.byte_rate != 32'd0) begin
                            r_seq <= SQ_MUL;
                        end else begin
                            r_out_valid <= 1'b1;
                        end
                    end
                end
                SQ_MUL: begin
                    r_cnt <= '0;
                    r_seq <= SQ_DIV;
                end
                SQ_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_out_valid <= 1'b1;
                        r_seq       <= SQ_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: begin
                    r_seq <= SQ_IDLE;
                end
            endcase
        end
    end

    // Result payload and divider datapath
    always_ff @(posedge i_clk) begin
        unique case (r_seq)
            SQ_IDLE: begin
                if (accept && res_valid) begin
                    r_out <= res_word;
                end
            end
            SQ_MUL: begin
                r_quo <= LEN_MS_W'(r_out.data_length) * LEN_MS_W'(MS_PER_S);
                r_rem <= 32'd0;
            end
            SQ_DIV: begin
                r_quo <= {r_quo[LEN_MS_W-2:0], div_ge};
                r_rem <= div_rem;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_out.length_ms <= {r_quo[LEN_MS_W-2:0], div_ge};
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // Checks
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != SQ_IDLE) |-> o_stall)
        else $error("input not stalled while duration is computed");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != SQ_IDLE) |-> !r_out_valid)
        else $error("result shown before duration is done");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_DIV && r_cnt == CNT_W'(DIV_STEPS - 1)) |=> (r_out_valid && r_out.last))
        else $error("last word not presented after divide");

    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == SQ_MUL) |=> (r_seq == SQ_DIV && r_cnt == '0))
        else $error("divider did not start after multiply");

endmodule
